// ===== src/dct_pkg.sv =====
// shared types and constants for the dual compressor thermostat
// no dependencies; imported by every module of the block except dct_checker
package dct_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 8;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_FRIDGE_MAX_RUN   = 3'd0,
    REG_FREEZER_MAX_RUN  = 3'd1,
    REG_FRIDGE_MIN_IDLE  = 3'd2,
    REG_FREEZER_MIN_IDLE = 3'd3,
    REG_FREEZER_MIN_RUN  = 3'd4,
    REG_FRIDGE_ALARM     = 3'd5,
    REG_FREEZER_ALARM    = 3'd6
  } reg_idx_t;

  // register reset values
  localparam logic [7:0]        FRIDGE_MAX_RUN_RST   = 8'd50;
  localparam logic [7:0]        FREEZER_MAX_RUN_RST  = 8'd60;
  localparam logic [7:0]        FRIDGE_MIN_IDLE_RST  = 8'd5;
  localparam logic [7:0]        FREEZER_MIN_IDLE_RST = 8'd5;
  localparam logic [7:0]        FREEZER_MIN_RUN_RST  = 8'd5;
  localparam logic signed [6:0] FRIDGE_ALARM_RST     = 7'sd4;
  localparam logic signed [6:0] FREEZER_ALARM_RST    = -7'sd18;

  // decision constants
  localparam logic signed [6:0] FRIDGE_WARM_MARK   = 7'sd6;
  localparam logic signed [6:0] FREEZER_WARM_MARK  = -7'sd13;
  localparam logic signed [7:0] FRIDGE_DIFF_LIMIT  = 8'sd2;
  localparam logic signed [7:0] FREEZER_DIFF_LIMIT = 8'sd3;
  localparam logic [7:0]        COUNT_MAX          = 8'd255;

  typedef struct packed {
    logic [7:0]        fridge_max_run;
    logic [7:0]        freezer_max_run;
    logic [7:0]        fridge_min_idle;
    logic [7:0]        freezer_min_idle;
    logic [7:0]        freezer_min_run;
    logic signed [6:0] fridge_alarm_temp;
    logic signed [6:0] freezer_alarm_temp;
  } cfg_t;

  // input item, last field in the lowest bits
  typedef struct packed {
    logic              freezer_off;
    logic signed [6:0] freezer_setpoint;
    logic              freezer_reading_ok;
    logic signed [6:0] freezer_reading;
    logic              fridge_off;
    logic signed [6:0] fridge_setpoint;
    logic              fridge_reading_ok;
    logic signed [6:0] fridge_reading;
  } in_item_t;

  // result item, last field in the lowest bits, zero padded to 24 bits
  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] freezer_run_count;
    logic [7:0] fridge_run_count;
    logic       alarm_blink;
    logic       freezer_alarm;
    logic       fridge_alarm;
    logic       freezer_relay;
    logic       fridge_relay;
  } out_item_t;

  // saturating minute increment
  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    sat_inc = (c == COUNT_MAX) ? COUNT_MAX : c + 8'd1;
  endfunction

endpackage

// ===== src/dct_cfg_regs.sv =====
// configuration register file of the thermostat
// depends on dct_pkg for register indexes, reset values and cfg_t
module dct_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [dct_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [dct_pkg::CfgDataW-1:0]   cfg_wr_data,
  output dct_pkg::cfg_t                  cfg
);
  import dct_pkg::*;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fridge_max_run     <= FRIDGE_MAX_RUN_RST;
      cfg.freezer_max_run    <= FREEZER_MAX_RUN_RST;
      cfg.fridge_min_idle    <= FRIDGE_MIN_IDLE_RST;
      cfg.freezer_min_idle   <= FREEZER_MIN_IDLE_RST;
      cfg.freezer_min_run    <= FREEZER_MIN_RUN_RST;
      cfg.fridge_alarm_temp  <= FRIDGE_ALARM_RST;
      cfg.freezer_alarm_temp <= FREEZER_ALARM_RST;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_addr))
        REG_FRIDGE_MAX_RUN:   cfg.fridge_max_run     <= cfg_wr_data;
        REG_FREEZER_MAX_RUN:  cfg.freezer_max_run    <= cfg_wr_data;
        REG_FRIDGE_MIN_IDLE:  cfg.fridge_min_idle    <= cfg_wr_data;
        REG_FREEZER_MIN_IDLE: cfg.freezer_min_idle   <= cfg_wr_data;
        REG_FREEZER_MIN_RUN:  cfg.freezer_min_run    <= cfg_wr_data;
        REG_FRIDGE_ALARM:     cfg.fridge_alarm_temp  <= cfg_wr_data[6:0];
        REG_FREEZER_ALARM:    cfg.freezer_alarm_temp <= cfg_wr_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dct_ctrl.sv =====
// compressor state, minute counters and the per-tick run/stop decision
// depends on dct_pkg for item types, cfg_t and decision constants
module dct_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  dct_pkg::in_item_t  item,
  input  dct_pkg::cfg_t      cfg,
  output dct_pkg::out_item_t result
);
  import dct_pkg::*;

  logic       fridge_on, freezer_on;
  logic [7:0] fridge_run, freezer_run, fridge_idle, freezer_idle;

  logic [7:0]        fridge_run_adv, freezer_run_adv, fridge_idle_adv, freezer_idle_adv;
  logic              fridge_demand, fridge_go, fridge_alarm;
  logic              freezer_demand, freezer_go, freezer_alarm;
  logic signed [7:0] fridge_diff, freezer_diff;
  logic [7:0]        fridge_idle_next, freezer_idle_next;

  // counter advance at the start of the tick
  always_comb begin
    fridge_run_adv   = fridge_on  ? sat_inc(fridge_run)  : 8'd0;
    fridge_idle_adv  = fridge_on  ? fridge_idle          : sat_inc(fridge_idle);
    freezer_run_adv  = freezer_on ? sat_inc(freezer_run) : 8'd0;
    freezer_idle_adv = freezer_on ? freezer_idle         : sat_inc(freezer_idle);
  end

  // fridge decision and alarm
  always_comb begin
    fridge_diff = {item.fridge_setpoint[6], item.fridge_setpoint}
                - {item.fridge_reading[6], item.fridge_reading};
    fridge_demand = item.fridge_reading_ok
                  && ((item.fridge_reading > item.fridge_setpoint)
                      || (item.fridge_reading == FRIDGE_WARM_MARK))
                  && (fridge_run_adv < cfg.fridge_max_run);
    fridge_alarm = !item.fridge_reading_ok
                 || (fridge_demand && ((fridge_diff > FRIDGE_DIFF_LIMIT)
                     || (item.fridge_reading > cfg.fridge_alarm_temp)));
    fridge_go = fridge_demand && !item.fridge_off
              && !(!fridge_on && (fridge_idle_adv < cfg.fridge_min_idle));
    fridge_idle_next = (fridge_on && !fridge_go) ? 8'd0 : fridge_idle_adv;
  end

  // freezer decision and alarm
  always_comb begin
    freezer_diff = {item.freezer_setpoint[6], item.freezer_setpoint}
                 - {item.freezer_reading[6], item.freezer_reading};
    freezer_demand = !item.freezer_off
                   && !(freezer_run_adv > cfg.freezer_max_run)
                   && item.freezer_reading_ok
                   && ((item.freezer_reading > item.freezer_setpoint)
                       || (item.freezer_reading == FREEZER_WARM_MARK));
    // minimum run holds a running freezer, minimum idle blocks a restart
    freezer_go = (freezer_demand
                  || (freezer_on && (freezer_run_adv < cfg.freezer_min_run)))
               && !(!freezer_on && (freezer_idle_adv < cfg.freezer_min_idle));
    freezer_alarm = !item.freezer_reading_ok || (freezer_diff > FREEZER_DIFF_LIMIT)
                  || (item.freezer_reading > cfg.freezer_alarm_temp);
    freezer_idle_next = (freezer_on && !freezer_go) ? 8'd0 : freezer_idle_adv;
  end

  // result of this tick
  always_comb begin
    result.pad               = '0;
    result.fridge_relay      = fridge_go;
    result.freezer_relay     = freezer_go;
    result.fridge_alarm      = fridge_alarm;
    result.freezer_alarm     = freezer_alarm;
    result.alarm_blink       = fridge_alarm || freezer_alarm;
    result.fridge_run_count  = fridge_run_adv;
    result.freezer_run_count = freezer_run_adv;
  end

  // compressor state update, one tick per request
  always_ff @(posedge clk) begin
    if (rst) begin
      fridge_on    <= 1'b0;
      freezer_on   <= 1'b0;
      fridge_run   <= 8'd0;
      freezer_run  <= 8'd0;
      fridge_idle  <= FRIDGE_MIN_IDLE_RST;
      freezer_idle <= FREEZER_MIN_IDLE_RST;
    end else if (fire) begin
      fridge_on    <= fridge_go;
      freezer_on   <= freezer_go;
      fridge_run   <= fridge_run_adv;
      freezer_run  <= freezer_run_adv;
      fridge_idle  <= fridge_idle_next;
      freezer_idle <= freezer_idle_next;
    end
  end

endmodule

// ===== src/dual_compressor_thermostat_unit.sv =====
// top level of the dual compressor thermostat
// depends on dct_pkg, dct_cfg_regs and dct_ctrl
//
// Usage: every request on the s_ channel is one minute tick carrying both
// compartment temperatures, setpoints, sensor valid flags and off flags.
// Each tick yields exactly one result on the m_ channel: relay drives,
// alarms, the blink alarm and both run-minute counts.
// The configuration port writes one register per cycle when cfg_wr_en is
// high; it is meant to be written while no tick is in flight.
// A request accepted into the input register shows on m_tvalid once the
// result register loads it; a stalled m_ channel holds it back.
// Throughput: one tick per cycle while m_tready does not stall the result;
// the compressor state registers in dct_ctrl update with each tick.
// Stall: while m_tready is low the result holds, the input register keeps
// one more request, and s_tready drops only when both are full.
// Reset: synchronous; both compressors stopped, run counts zero, idle
// counts at the minimum idle reset value so either may start at once,
// registers at their reset values, both channels empty.
module dual_compressor_thermostat_unit (
  input  logic                         clk,
  input  logic                         rst,
  // fridge_reading, fridge_reading_ok, fridge_setpoint, fridge_off,
  // freezer_reading, freezer_reading_ok, freezer_setpoint, freezer_off
  input  logic [31:0]                  s_tdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // fridge_relay, freezer_relay, fridge_alarm, freezer_alarm, alarm_blink,
  // fridge_run_count, freezer_run_count, zero padding
  output logic [23:0]                  m_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic                         cfg_wr_en,
  input  logic [dct_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [dct_pkg::CfgDataW-1:0] cfg_wr_data
);
  import dct_pkg::*;

  cfg_t      cfg;
  in_item_t  in_reg;
  logic      in_valid;
  out_item_t result;
  out_item_t out_reg;
  logic      advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign m_tdata  = out_reg;

  dct_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  dct_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .fire   (in_valid && advance),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_reg <= in_item_t'(s_tdata);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_reg <= result;
    end
  end

endmodule

// ===== src/dct_checker.sv =====
// port-level checks for the thermostat top level
// no package dependency; bound to dual_compressor_thermostat_unit below
module dct_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] m_tdata,
  input logic        m_tvalid,
  input logic        m_tready
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // an accepted request leaves a valid output once it has passed the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ##1 m_tvalid)
    else $error("request produced no result");

  // blink alarm is the or of both alarms
  a_blink: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4] == (m_tdata[2] || m_tdata[3])))
    else $error("blink alarm mismatch");

endmodule

bind dual_compressor_thermostat_unit dct_checker u_dct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// ===== dv/dual_compressor_thermostat_unit_tb.sv =====
// self-checking testbench for dual_compressor_thermostat_unit: minute ticks on the s_ stream,
// results checked against an in-bench thermostat predictor, register writes between phases
// depends on dct_pkg and dual_compressor_thermostat_unit
module dual_compressor_thermostat_unit_tb;
  import dct_pkg::*;

  localparam int FRIDGE_MARK_DEG  = 6;
  localparam int FREEZER_MARK_DEG = -13;
  localparam int FRIDGE_GAP_DEG   = 2;
  localparam int FREEZER_GAP_DEG  = 3;
  localparam int HOLD_CYCLES      = 400;
  localparam logic [CfgAddrW-1:0] REG_SPARE = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic [31:0]         s_tdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [23:0]         m_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wr_data = '0;

  // requests waiting to be sent and results waiting to be seen
  in_item_t  pending_ticks[$];
  out_item_t expected_outputs[$];

  int send_idle_pct = 15;
  int recv_idle_pct = 80;
  int mismatches = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  // predictor copy of the registers
  logic [7:0] fridge_max_run_cfg   = FRIDGE_MAX_RUN_RST;
  logic [7:0] freezer_max_run_cfg  = FREEZER_MAX_RUN_RST;
  logic [7:0] fridge_min_idle_cfg  = FRIDGE_MIN_IDLE_RST;
  logic [7:0] freezer_min_idle_cfg = FREEZER_MIN_IDLE_RST;
  logic [7:0] freezer_min_run_cfg  = FREEZER_MIN_RUN_RST;
  int         fridge_alarm_cfg     = 4;
  int         freezer_alarm_cfg    = -18;

  // predictor copy of the compressor state
  bit         fridge_cooling  = 1'b0;
  bit         freezer_cooling = 1'b0;
  logic [7:0] fridge_run_min  = 8'd0;
  logic [7:0] freezer_run_min = 8'd0;
  logic [7:0] fridge_idle_min  = FRIDGE_MIN_IDLE_RST;
  logic [7:0] freezer_idle_min = FREEZER_MIN_IDLE_RST;

  // sticky warm/cold trend used by the random tick generator
  bit fridge_warm  = 1'b0;
  bit freezer_warm = 1'b0;

  dual_compressor_thermostat_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tdata     (m_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] bump_minute(input logic [7:0] c);
    return (c == 8'hFF) ? c : c + 8'd1;
  endfunction

  function automatic logic signed [6:0] to_deg(input int v);
    if (v > 63) v = 63;
    if (v < -64) v = -64;
    return 7'(v);
  endfunction

  // one minute tick of both compressors
  function automatic out_item_t thermostat_minute(input in_item_t t);
    int        ft, fs, zt, zs;
    bit        fridge_go, freezer_go, fridge_alm, freezer_alm;
    out_item_t r;
    ft = $signed(t.fridge_reading);
    fs = $signed(t.fridge_setpoint);
    zt = $signed(t.freezer_reading);
    zs = $signed(t.freezer_setpoint);
    fridge_go = 1'b0;
    freezer_go = 1'b0;
    fridge_alm = 1'b0;

    // minute counters
    if (fridge_cooling) begin
      fridge_run_min = bump_minute(fridge_run_min);
    end else begin
      fridge_run_min = 8'd0;
      fridge_idle_min = bump_minute(fridge_idle_min);
    end
    if (freezer_cooling) begin
      freezer_run_min = bump_minute(freezer_run_min);
    end else begin
      freezer_run_min = 8'd0;
      freezer_idle_min = bump_minute(freezer_idle_min);
    end

    // fridge demand, alarm only judged while demand holds or set by an invalid sensor
    if ((ft > fs || ft == FRIDGE_MARK_DEG) && t.fridge_reading_ok &&
        fridge_run_min < fridge_max_run_cfg) begin
      fridge_go = 1'b1;
      fridge_alm = (fs > ft && (fs - ft) > FRIDGE_GAP_DEG) || ft > fridge_alarm_cfg;
    end
    if (!t.fridge_reading_ok) fridge_alm = 1'b1;
    if (!fridge_cooling && fridge_go && fridge_idle_min < fridge_min_idle_cfg) fridge_go = 1'b0;
    if (t.fridge_off) fridge_go = 1'b0;

    // freezer demand, minimum run beats the off flag and max run
    if (t.freezer_off) begin
      freezer_go = 1'b0;
    end else if (freezer_run_min > freezer_max_run_cfg) begin
      freezer_go = 1'b0;
    end else if ((zt > zs || zt == FREEZER_MARK_DEG) && t.freezer_reading_ok) begin
      freezer_go = 1'b1;
    end
    if (freezer_cooling && !freezer_go && freezer_run_min < freezer_min_run_cfg)
      freezer_go = 1'b1;
    if (!freezer_cooling && freezer_go && freezer_idle_min < freezer_min_idle_cfg)
      freezer_go = 1'b0;

    // relays, a stop clears the idle count
    if (fridge_go && !fridge_cooling) begin
      fridge_cooling = 1'b1;
    end else if (!fridge_go && fridge_cooling) begin
      fridge_cooling = 1'b0;
      fridge_idle_min = 8'd0;
    end
    if (freezer_go && !freezer_cooling) begin
      freezer_cooling = 1'b1;
    end else if (!freezer_go && freezer_cooling) begin
      freezer_cooling = 1'b0;
      freezer_idle_min = 8'd0;
    end

    freezer_alm = (zs > zt && (zs - zt) > FREEZER_GAP_DEG) || zt > freezer_alarm_cfg;
    if (!t.freezer_reading_ok) freezer_alm = 1'b1;

    r = '0;
    r.fridge_relay      = fridge_cooling;
    r.freezer_relay     = freezer_cooling;
    r.fridge_alarm      = fridge_alm;
    r.freezer_alarm     = freezer_alm;
    r.alarm_blink       = fridge_alm | freezer_alm;
    r.fridge_run_count  = fridge_run_min;
    r.freezer_run_count = freezer_run_min;
    return r;
  endfunction

  // sender: one request per handshake, prediction at acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_outputs.push_back(thermostat_minute(in_item_t'(s_tdata)));
      if (!s_tvalid || s_tready) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tdata  <= pending_ticks.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d at %0t", name, want_v, got_v, $realtime);
    end
  endtask

  // receiver: compare each result with the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = out_item_t'(m_tdata);
        if (expected_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with no request pending: %h", m_tdata);
        end else begin
          want = expected_outputs.pop_front();
          check_field("fridge_relay", 8'(want.fridge_relay), 8'(got.fridge_relay));
          check_field("freezer_relay", 8'(want.freezer_relay), 8'(got.freezer_relay));
          check_field("fridge_alarm", 8'(want.fridge_alarm), 8'(got.fridge_alarm));
          check_field("freezer_alarm", 8'(want.freezer_alarm), 8'(got.freezer_alarm));
          check_field("alarm_blink", 8'(want.alarm_blink), 8'(got.alarm_blink));
          check_field("fridge_run_count", want.fridge_run_count, got.fridge_run_count);
          check_field("freezer_run_count", want.freezer_run_count, got.freezer_run_count);
          check_field("pad", 8'(want.pad), 8'(got.pad));
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic add_tick(input int ft, input bit fv, input int fs, input bit foff,
                          input int zt, input bit zv, input int zs, input bit zoff);
    in_item_t t;
    t.fridge_reading     = to_deg(ft);
    t.fridge_reading_ok  = fv;
    t.fridge_setpoint    = to_deg(fs);
    t.fridge_off         = foff;
    t.freezer_reading    = to_deg(zt);
    t.freezer_reading_ok = zv;
    t.freezer_setpoint   = to_deg(zs);
    t.freezer_off        = zoff;
    pending_ticks.push_back(t);
  endtask

  // temperatures follow a slowly flipping warm/cold trend around random setpoints, apart from fully random noise ticks
  task automatic add_random_ticks(input int count, input int toggle_div, input int noise_pct);
    in_item_t t;
    int       fs, zs, ft, zt;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, toggle_div - 1) == 0) fridge_warm = ~fridge_warm;
      if ($urandom_range(0, toggle_div - 1) == 0) freezer_warm = ~freezer_warm;
      if (int'($urandom_range(0, 99)) < noise_pct) begin
        t = in_item_t'($urandom);
      end else begin
        fs = int'($urandom_range(0, 120)) - 60;
        zs = int'($urandom_range(0, 120)) - 60;
        ft = fridge_warm ? fs + int'($urandom_range(1, 4)) : fs - int'($urandom_range(0, 6));
        zt = freezer_warm ? zs + int'($urandom_range(1, 4)) : zs - int'($urandom_range(0, 6));
        if ($urandom_range(0, 15) == 0) ft = FRIDGE_MARK_DEG;
        if ($urandom_range(0, 15) == 0) zt = FREEZER_MARK_DEG;
        t.fridge_reading     = to_deg(ft);
        t.fridge_setpoint    = to_deg(fs);
        t.freezer_reading    = to_deg(zt);
        t.freezer_setpoint   = to_deg(zs);
        t.fridge_reading_ok  = (noise_pct == 0) || ($urandom_range(0, 19) != 0);
        t.freezer_reading_ok = (noise_pct == 0) || ($urandom_range(0, 19) != 0);
        t.fridge_off         = (noise_pct != 0) && ($urandom_range(0, 24) == 0);
        t.freezer_off        = (noise_pct != 0) && ($urandom_range(0, 24) == 0);
      end
      pending_ticks.push_back(t);
    end
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= val;
    case (idx)
      REG_FRIDGE_MAX_RUN:   fridge_max_run_cfg = val;
      REG_FREEZER_MAX_RUN:  freezer_max_run_cfg = val;
      REG_FRIDGE_MIN_IDLE:  fridge_min_idle_cfg = val;
      REG_FREEZER_MIN_IDLE: freezer_min_idle_cfg = val;
      REG_FREEZER_MIN_RUN:  freezer_min_run_cfg = val;
      REG_FRIDGE_ALARM:     fridge_alarm_cfg = $signed(val[6:0]);
      REG_FREEZER_ALARM:    freezer_alarm_cfg = $signed(val[6:0]);
      default: ;
    endcase
  endtask

  // full register set plus a write to the unused index, bit 7 of alarm writes is noise
  task automatic apply_settings(input logic [7:0] fmax, input logic [7:0] zmax,
                                input logic [7:0] fidle, input logic [7:0] zidle,
                                input logic [7:0] zrun, input int falarm, input int zalarm);
    write_reg(REG_FRIDGE_MAX_RUN, fmax);
    write_reg(REG_FREEZER_MAX_RUN, zmax);
    write_reg(REG_FRIDGE_MIN_IDLE, fidle);
    write_reg(REG_FREEZER_MIN_IDLE, zidle);
    write_reg(REG_FREEZER_MIN_RUN, zrun);
    write_reg(REG_FRIDGE_ALARM, {1'($urandom_range(0, 1)), to_deg(falarm)});
    write_reg(REG_FREEZER_ALARM, {1'($urandom_range(0, 1)), to_deg(zalarm)});
    write_reg(REG_SPARE, 8'($urandom));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender pauses until every result is back
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || s_tvalid || expected_outputs.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed ticks at reset settings
    add_tick(-64, 0, -64, 0, -64, 0, -64, 0);  // all minimum, both sensors invalid
    add_tick(63, 1, 63, 1, 63, 1, 63, 1);      // all maximum, both off
    add_tick(6, 1, 10, 0, -13, 1, -10, 0);     // warm marks start both
    add_tick(6, 1, 6, 0, -13, 1, -13, 0);      // warm marks at setpoint
    add_tick(6, 1, 8, 0, -20, 1, -17, 0);      // fridge gap at limit, freezer held by min run
    add_tick(2, 1, 0, 0, -20, 1, -15, 1);      // freezer off overridden by min run
    add_tick(5, 1, 0, 1, -17, 1, -20, 1);      // fridge off, freezer above alarm temp
    add_tick(5, 1, 0, 0, -25, 0, -30, 0);      // fridge restart blocked, freezer invalid
    repeat (6) add_tick(3, 1, -2, 0, -25, 1, -22, 1);  // fridge waits out idle time
    add_tick(4, 0, 0, 0, -30, 1, -20, 0);      // fridge sensor lost while running
    add_tick(-10, 1, -5, 0, -40, 1, -10, 0);   // both cold, large freezer gap
    add_tick(63, 1, -64, 0, 63, 1, -64, 0);    // widest warm difference
    add_tick(-64, 1, 63, 0, -64, 1, 63, 0);    // widest cold difference
    wait_drained();

    // low extremes
    apply_settings(8'd1, 8'd1, 8'd0, 8'd0, 8'd0, -64, 63);
    add_random_ticks(100, 8, 10);
    wait_drained();

    // short limits, receiver hold-off fills the block
    send_idle_pct = 80;
    recv_idle_pct = 15;
    apply_settings(8'($urandom_range(2, 8)), 8'($urandom_range(2, 8)),
                   8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                   8'($urandom_range(2, 8)), int'($urandom_range(0, 127)) - 64,
                   int'($urandom_range(0, 127)) - 64);
    add_random_ticks(100, 10, 10);
    hold_requests <= hold_requests + 1;
    wait_drained();

    // high extremes with steady demand, counters run into saturation
    apply_settings(8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 63, -64);
    fridge_warm = 1'b1;
    freezer_warm = 1'b1;
    add_random_ticks(280, 1000, 0);
    wait_drained();

    // long minimum idle, no random idling on either side, one receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(8'd10, 8'd20, 8'd255, 8'd255, 8'($urandom), -5, -20);
    fridge_warm = 1'b0;
    freezer_warm = 1'b0;
    add_random_ticks(120, 150, 5);
    hold_requests <= hold_requests + 1;
    wait_drained();
    add_random_ticks(120, 150, 5);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/dct_pkg.sv
src/dct_cfg_regs.sv
src/dct_ctrl.sv
src/dual_compressor_thermostat_unit.sv
src/dct_checker.sv
dv/dual_compressor_thermostat_unit_tb.sv
